### rtl/core/kpa_pkg.sv
// ----------------------------------------------------------------------------
// kpa_pkg
// Shared types and constants for the keypad press / auto-repeat block.
// ----------------------------------------------------------------------------
package kpa_pkg;

    // Key vectors are always carried at full matrix width (8 x 8)
    localparam int KEY_VEC_W = 64;
    localparam int KEY_IDX_W = 6;
    localparam int KEY_MAX   = 64;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int TICK_W    = 32;
    localparam int DELAY_W   = 31;

    // Stream payload widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 8;

    // Configuration register indexes
    localparam int            CFG_IDX_W           = 2;
    localparam logic [1:0]    CFG_INITIAL_DELAY   = 2'd0;
    localparam logic [1:0]    CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [1:0]    CFG_REPEAT_KEY_MASK = 2'd2;

    localparam logic [DELAY_W-1:0]   RST_INITIAL_DELAY   = 31'd500;
    localparam logic [DELAY_W-1:0]   RST_REPEAT_INTERVAL = 31'd100;
    localparam logic [KEY_VEC_W-1:0] RST_REPEAT_KEY_MASK = 64'h0000_0000_0018_1800;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_UI_SCAN    = 2'd0,
        REQ_GAME_SCAN  = 2'd1,
        REQ_CLR_UI     = 2'd2,
        REQ_CLR_GAME   = 2'd3
    } kpa_req_t;

    // One queued request
    typedef struct packed {
        kpa_req_t               req;
        logic [KEY_VEC_W-1:0]   matrix;
        logic                   modifier_on;
        logic [TICK_W-1:0]      tick_now;
    } kpa_item_t;

    // Live configuration
    typedef struct packed {
        logic [DELAY_W-1:0]     initial_delay;
        logic [DELAY_W-1:0]     repeat_interval;
        logic [KEY_VEC_W-1:0]   repeat_key_mask;
    } kpa_cfg_t;

endpackage

### rtl/core/kpa_front.sv
// ----------------------------------------------------------------------------
// kpa_front
// Accepts request beats, masks the key matrix to the populated key space
// and holds them in a two-entry queue for the key walker.
// ----------------------------------------------------------------------------
module kpa_front #(
    parameter int NUM_KEYS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [63:0] key_matrix, [64] modifier_on, [96:65] tick_now, rest zero
    input  logic [kpa_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]                    s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output kpa_pkg::kpa_item_t            q_item
);
    import kpa_pkg::*;

    localparam logic [KEY_VEC_W-1:0] KEY_SPACE =
        (NUM_KEYS >= KEY_MAX) ? {KEY_VEC_W{1'b1}}
                              : ((KEY_VEC_W'(1) << NUM_KEYS) - KEY_VEC_W'(1));

    kpa_item_t   q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    kpa_item_t   in_item;

    // Unpack and classify the incoming beat
    always_comb
    begin
        in_item.req         = kpa_req_t'(s_tuser);
        in_item.matrix      = s_tdata[63:0] & KEY_SPACE;
        in_item.modifier_on = s_tdata[64];
        in_item.tick_now    = s_tdata[96:65];
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/kpa_back.sv
// ----------------------------------------------------------------------------
// kpa_back
// Key walker: takes one request from the queue, walks the keys in row-major
// order (one per cycle unless the output stalls) against the held / armed
// state and deadline memory, and emits press beats via an output register.
// ----------------------------------------------------------------------------
module kpa_back #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kpa_pkg::kpa_cfg_t             cfg,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  kpa_pkg::kpa_item_t            q_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] press_row, [5:3] press_col, [6] any_ui_held, [7] zero
    output logic [kpa_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] press_valid
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import kpa_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t                 state_reg, state_next;

    // Held / armed state
    logic [KEY_VEC_W-1:0]   ui_held_reg, ui_held_next;
    logic [KEY_VEC_W-1:0]   game_held_reg, game_held_next;
    logic [KEY_VEC_W-1:0]   armed_reg, armed_next;
    logic [KEY_VEC_W-1:0]   dvalid_reg, dvalid_next;

    // Current request
    kpa_item_t              item_reg, item_next;
    logic                   any_reg, any_next;

    // Read side of the walk
    logic [KEY_IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ROW_W-1:0]       rd_row_reg, rd_row_next;
    logic [COL_W-1:0]       rd_col_reg, rd_col_next;
    logic                   rd_more_reg, rd_more_next;

    // Evaluate side of the walk
    logic                   ev_valid_reg, ev_valid_next;
    logic [KEY_IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    logic [ROW_W-1:0]       ev_row_reg, ev_row_next;
    logic [COL_W-1:0]       ev_col_reg, ev_col_next;

    // Held-back press, so the final one can carry tlast
    logic                   pend_valid_reg, pend_valid_next;
    logic [ROW_W-1:0]       pend_row_reg, pend_row_next;
    logic [COL_W-1:0]       pend_col_reg, pend_col_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_press_reg, out_press_next;
    logic [ROW_W-1:0]       out_row_reg, out_row_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_any_reg, out_any_next;

    // Deadline memory
    logic [TICK_W-1:0]      dl_mem [KEY_MAX];
    logic [TICK_W-1:0]      rdata_reg;
    logic                   mem_re, mem_we;
    logic [TICK_W-1:0]      mem_wdata;

    // Per-key evaluation
    logic                   adv;
    logic                   k_down, k_held, k_armed, k_mask;
    logic [TICK_W-1:0]      k_deadline, k_diff;
    logic                   k_emit, k_write, k_arm_set, k_arm_clr;

    assign adv      = !(out_valid_reg && !m_tready);
    assign q_ready  = (state_reg == ST_IDLE);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_press_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_any_reg, out_col_reg, out_row_reg};

    // Decide what happens to the key under evaluation
    always_comb
    begin
        k_down     = item_reg.matrix[ev_idx_reg];
        k_held     = ui_held_reg[ev_idx_reg];
        k_armed    = armed_reg[ev_idx_reg];
        k_mask     = cfg.repeat_key_mask[ev_idx_reg];
        k_deadline = dvalid_reg[ev_idx_reg] ? rdata_reg : '0;
        k_diff     = item_reg.tick_now - k_deadline;
        k_emit     = 1'b0;
        k_write    = 1'b0;
        k_arm_set  = 1'b0;
        k_arm_clr  = 1'b0;
        mem_wdata  = item_reg.tick_now + {1'b0, cfg.initial_delay};
        if (item_reg.req == REQ_GAME_SCAN)
        begin
            k_emit = k_down && !game_held_reg[ev_idx_reg];
        end
        else if (k_down && !k_held)
        begin
            // new key-down: arm if repeatable, start the initial delay
            k_arm_set = k_mask && !item_reg.modifier_on;
            k_arm_clr = !k_arm_set;
            k_write   = 1'b1;
            k_emit    = 1'b1;
        end
        else if (k_down && k_armed)
        begin
            if (item_reg.modifier_on)
            begin
                k_arm_clr = 1'b1;
            end
            else if (!k_diff[TICK_W-1])
            begin
                k_emit    = 1'b1;
                k_write   = 1'b1;
                mem_wdata = item_reg.tick_now + {1'b0, cfg.repeat_interval};
            end
        end
        else if (!k_down)
        begin
            k_arm_clr = 1'b1;
        end
    end

    assign mem_re = (state_reg == ST_RUN) && adv && rd_more_reg;
    assign mem_we = (state_reg == ST_RUN) && adv && ev_valid_reg && k_write;

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        ui_held_next    = ui_held_reg;
        game_held_next  = game_held_reg;
        armed_next      = armed_reg;
        dvalid_next     = dvalid_reg;
        item_next       = item_reg;
        any_next        = any_reg;
        rd_idx_next     = rd_idx_reg;
        rd_row_next     = rd_row_reg;
        rd_col_next     = rd_col_reg;
        rd_more_next    = rd_more_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        ev_row_next     = ev_row_reg;
        ev_col_next     = ev_col_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_press_next  = out_press_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_last_next   = out_last_reg;
        out_any_next    = out_any_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_next       = q_item;
                    pend_valid_next = 1'b0;
                    rd_idx_next     = '0;
                    rd_row_next     = '0;
                    rd_col_next     = '0;
                    rd_more_next    = 1'b1;
                    ev_valid_next   = 1'b0;
                    case (q_item.req)
                        REQ_UI_SCAN:
                        begin
                            any_next   = |q_item.matrix;
                            state_next = ST_RUN;
                        end
                        REQ_GAME_SCAN:
                        begin
                            any_next   = |ui_held_reg;
                            state_next = ST_RUN;
                        end
                        REQ_CLR_UI:
                        begin
                            ui_held_next = '0;
                            armed_next   = '0;
                            dvalid_next  = '0;
                            any_next     = 1'b0;
                            state_next   = ST_FLUSH;
                        end
                        default:
                        begin
                            game_held_next = '0;
                            any_next       = |ui_held_reg;
                            state_next     = ST_FLUSH;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                if (adv)
                begin
                    // issue the next read
                    if (rd_more_reg)
                    begin
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_idx_reg;
                        ev_row_next   = rd_row_reg;
                        ev_col_next   = rd_col_reg;
                        rd_idx_next   = rd_idx_reg + KEY_IDX_W'(1);
                        if (rd_col_reg == LAST_COL)
                        begin
                            rd_col_next = '0;
                            if (rd_row_reg == LAST_ROW)
                            begin
                                rd_more_next = 1'b0;
                            end
                            else
                            begin
                                rd_row_next = rd_row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            rd_col_next = rd_col_reg + COL_W'(1);
                        end
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end

                    // evaluate the key whose deadline read has arrived
                    if (ev_valid_reg)
                    begin
                        if (k_arm_set)
                        begin
                            armed_next[ev_idx_reg] = 1'b1;
                        end
                        if (k_arm_clr)
                        begin
                            armed_next[ev_idx_reg] = 1'b0;
                        end
                        if (k_write)
                        begin
                            dvalid_next[ev_idx_reg] = 1'b1;
                        end
                        if (k_emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_press_next = 1'b1;
                                out_row_next   = pend_row_reg;
                                out_col_next   = pend_col_reg;
                                out_last_next  = 1'b0;
                                out_any_next   = any_reg;
                            end
                            pend_valid_next = 1'b1;
                            pend_row_next   = ev_row_reg;
                            pend_col_next   = ev_col_reg;
                        end
                        if (!rd_more_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                if (adv)
                begin
                    // final beat: the held-back press, or a no-press beat
                    out_valid_next = 1'b1;
                    out_press_next = pend_valid_reg;
                    out_row_next   = pend_valid_reg ? pend_row_reg : '0;
                    out_col_next   = pend_valid_reg ? pend_col_reg : '0;
                    out_last_next  = 1'b1;
                    out_any_next   = any_reg;
                    if (item_reg.req == REQ_UI_SCAN)
                    begin
                        ui_held_next = item_reg.matrix;
                    end
                    else if (item_reg.req == REQ_GAME_SCAN)
                    begin
                        game_held_next = item_reg.matrix;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ui_held_reg    <= '0;
            game_held_reg  <= '0;
            armed_reg      <= '0;
            dvalid_reg     <= '0;
            rd_more_reg    <= 1'b0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ui_held_reg    <= ui_held_next;
            game_held_reg  <= game_held_next;
            armed_reg      <= armed_next;
            dvalid_reg     <= dvalid_next;
            rd_more_reg    <= rd_more_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        any_reg       <= any_next;
        rd_idx_reg    <= rd_idx_next;
        rd_row_reg    <= rd_row_next;
        rd_col_reg    <= rd_col_next;
        ev_idx_reg    <= ev_idx_next;
        ev_row_reg    <= ev_row_next;
        ev_col_reg    <= ev_col_next;
        pend_row_reg  <= pend_row_next;
        pend_col_reg  <= pend_col_next;
        out_press_reg <= out_press_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
        out_any_reg   <= out_any_next;
    end

    // Deadline memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dl_mem[ev_idx_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= dl_mem[rd_idx_reg];
        end
    end

endmodule

### rtl/core/keypad_press_autorepeat.sv
// ----------------------------------------------------------------------------
// keypad_press_autorepeat
// Keypad press detector with typematic auto-repeat for UI scans and plain
// edge detection for game scans.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per beat: a full key matrix scan (UI or game),
//   or a request to clear the UI or game held state. req_type rides on
//   s_tuser. m_* returns one beat per key press event, in row-major key
//   order; m_tlast marks the final beat of a request. A request with no
//   press returns a single beat with m_tuser (press_valid) low.
//   cfg_* writes initial_delay (0), repeat_interval (1) and
//   repeat_key_mask (2); write it only while the block is idle.
//   The key walker visits one key per cycle while the output is not
//   stalled, with one registered deadline read and at most one deadline
//   write per cycle; a clear skips the walk. A two-deep request queue
//   accepts beats while a scan is walked. Each press is held back until
//   the next press or the end of the walk so the last one can carry
//   m_tlast.
//   Reset clears all held, armed and deadline state (per-entry valid bits)
//   and loads the default configuration. When m_tready is low the walker
//   freezes in place; no beat is dropped.
// ----------------------------------------------------------------------------
module keypad_press_autorepeat #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [63:0] key_matrix, [64] modifier_on, [96:65] tick_now, [103:97] zero
    input  logic [kpa_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]                    s_tuser,
    // press channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] press_row, [5:3] press_col, [6] any_ui_held, [7] zero
    output logic [kpa_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] press_valid
    output logic                          m_tuser,
    // last_result
    output logic                          m_tlast,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kpa_pkg::KEY_VEC_W-1:0] cfg_data
);
    import kpa_pkg::*;

    kpa_cfg_t   cfg_reg;
    logic       q_valid, q_ready;
    kpa_item_t  q_item;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay   <= RST_INITIAL_DELAY;
            cfg_reg.repeat_interval <= RST_REPEAT_INTERVAL;
            cfg_reg.repeat_key_mask <= RST_REPEAT_KEY_MASK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INITIAL_DELAY:   cfg_reg.initial_delay   <= cfg_data[DELAY_W-1:0];
                CFG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= cfg_data[DELAY_W-1:0];
                CFG_REPEAT_KEY_MASK: cfg_reg.repeat_key_mask <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Request intake and queue
    kpa_front #(
        .NUM_KEYS (ROWS * COLS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // Key walker and press output
    kpa_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keypad_press_autorepeat. Scan and clear requests
// stream in on s_*, every accepted request is run through a local model of
// the held / armed / deadline state, and each press beat on m_* is checked
// field by field against the oldest expected beat. A directed table covers
// reset defaults, full matrices, repeat timing around the deadline, the
// modifier and tick wrap. Random phases follow under several timing and
// mask settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

    import kpa_pkg::*;

    localparam int          KP_ROWS   = 8;
    localparam int          KP_COLS   = 8;
    localparam int          NUM_KEYS  = KP_ROWS * KP_COLS;
    localparam logic [63:0] KEY_SPACE = (NUM_KEYS >= 64) ? '1 : ((64'd1 << NUM_KEYS) - 64'd1);
    localparam logic [63:0] ALL_KEYS  = '1;

    // One result beat as seen on m_*
    typedef struct packed {
        logic       press_valid;
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
        logic       held;
    } press_beat_t;

    // Directed stimulus; quiet rows carry a single no-press beat typed in
    typedef struct {
        kpa_req_t    req;
        logic [63:0] keys;
        logic        modif;
        logic [31:0] tick;
        bit          quiet;
        bit          held;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{REQ_CLR_UI,    64'h0,                   1'b0, 32'h0000_0000, 1'b1, 1'b0},
        '{REQ_CLR_GAME,  64'h0,                   1'b0, 32'h0000_0000, 1'b1, 1'b0},
        '{REQ_UI_SCAN,   64'h0,                   1'b0, 32'h0000_0000, 1'b1, 1'b0},
        '{REQ_UI_SCAN,   ALL_KEYS,                1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{REQ_UI_SCAN,   ALL_KEYS,                1'b0, 32'd499,       1'b1, 1'b1},
        '{REQ_UI_SCAN,   ALL_KEYS,                1'b0, 32'd500,       1'b0, 1'b0},
        '{REQ_UI_SCAN,   ALL_KEYS,                1'b0, 32'd600,       1'b0, 1'b0},
        '{REQ_UI_SCAN,   ALL_KEYS,                1'b1, 32'd700,       1'b1, 1'b1},
        '{REQ_UI_SCAN,   ALL_KEYS,                1'b0, 32'd800,       1'b1, 1'b1},
        '{REQ_UI_SCAN,   64'h0,                   1'b0, 32'd900,       1'b1, 1'b0},
        '{REQ_GAME_SCAN, ALL_KEYS,                1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{REQ_GAME_SCAN, ALL_KEYS,                1'b1, 32'd5,         1'b1, 1'b0},
        '{REQ_CLR_GAME,  ALL_KEYS,                1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{REQ_GAME_SCAN, 64'h8000_0000_0000_0001, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{REQ_UI_SCAN,   64'h0000_0000_0000_0800, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b0},
        '{REQ_UI_SCAN,   64'h0,                   1'b0, 32'hFFFF_FF00, 1'b1, 1'b0},
        '{REQ_UI_SCAN,   64'h0000_0000_0000_0800, 1'b0, 32'hFFFF_FF00, 1'b0, 1'b0},
        '{REQ_UI_SCAN,   64'h0000_0000_0000_0800, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1},
        '{REQ_UI_SCAN,   64'h0000_0000_0000_0800, 1'b0, 32'h0000_00F4, 1'b0, 1'b0},
        '{REQ_UI_SCAN,   64'h0000_0000_0000_0800, 1'b0, 32'h8000_0158, 1'b0, 1'b0},
        '{REQ_UI_SCAN,   64'h0000_0000_0018_1800, 1'b0, 32'h8000_0200, 1'b0, 1'b0},
        '{REQ_CLR_UI,    64'h0,                   1'b0, 32'h8000_0300, 1'b1, 1'b0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = REQ_UI_SCAN;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_INITIAL_DELAY;
    logic [KEY_VEC_W-1:0] cfg_data = '0;

    // Model state and live configuration
    logic [63:0]        ui_held;
    logic [63:0]        game_held;
    logic [63:0]        armed;
    logic [31:0]        deadline [64];
    logic [DELAY_W-1:0] cfg_delay;
    logic [DELAY_W-1:0] cfg_interval;
    logic [63:0]        cfg_mask;

    press_beat_t item_presses [$];
    press_beat_t expected_presses [$];
    press_beat_t want;

    // Random stimulus state
    logic [31:0] tick_cnt = '0;
    logic [63:0] last_keys = '0;
    bit          idle_on = 1'b1;
    int          sink_hold = 0;

    int n_fail = 0;
    int n_items = 0;
    int n_beats = 0;
    int n_presses = 0;
    int n_settings = 1;

    keypad_press_autorepeat #(
        .ROWS(KP_ROWS),
        .COLS(KP_COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones; none while idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Walk one request through the key state; fills item_presses
    function automatic void scan_keypad(input kpa_req_t req, input logic [63:0] keys,
                                        input logic modif, input logic [31:0] tick);
        logic [63:0] down_v;
        logic [31:0] lag;
        int          idx;
        bit          fire;
        item_presses.delete();
        down_v = keys & KEY_SPACE;
        case (req)
            REQ_CLR_UI:
            begin
                ui_held = '0;
                armed   = '0;
                for (int i = 0; i < 64; i++)
                    deadline[i] = '0;
            end
            REQ_CLR_GAME:
                game_held = '0;
            default:
            begin
                for (int r = 0; r < KP_ROWS; r++)
                begin
                    for (int c = 0; c < KP_COLS; c++)
                    begin
                        idx  = r * KP_COLS + c;
                        fire = 1'b0;
                        if (req == REQ_GAME_SCAN)
                            fire = down_v[idx] && !game_held[idx];
                        else if (down_v[idx] && !ui_held[idx])
                        begin
                            // new key-down: press now, arm if repeatable
                            armed[idx]    = cfg_mask[idx] && !modif;
                            deadline[idx] = tick + {1'b0, cfg_delay};
                            fire          = 1'b1;
                        end
                        else if (down_v[idx] && armed[idx])
                        begin
                            if (modif)
                                armed[idx] = 1'b0;
                            else
                            begin
                                // wrap-safe: deadline reached when difference is non-negative
                                lag = tick - deadline[idx];
                                if (!lag[31])
                                begin
                                    fire          = 1'b1;
                                    deadline[idx] = tick + {1'b0, cfg_interval};
                                end
                            end
                        end
                        else if (!down_v[idx])
                            armed[idx] = 1'b0;
                        if (fire)
                            item_presses.push_back('{1'b1, 3'(r), 3'(c), 1'b0, 1'b0});
                    end
                end
                if (req == REQ_GAME_SCAN)
                    game_held = down_v;
                else
                    ui_held = down_v;
            end
        endcase
        if (item_presses.size() == 0)
            item_presses.push_back('{1'b0, 3'd0, 3'd0, 1'b0, 1'b0});
        item_presses[item_presses.size() - 1].last = 1'b1;
        foreach (item_presses[i])
            item_presses[i].held = |(ui_held & KEY_SPACE);
    endfunction

    // Offer one request, hold it until accepted, then log its expected beats
    task automatic send_item(input kpa_req_t req, input logic [63:0] keys, input logic modif,
                             input logic [31:0] tick, input bit quiet, input bit held);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, tick, modif, keys};
        do @(posedge clk); while (!s_tready);
        scan_keypad(req, keys, modif, tick);
        if (quiet)
            expected_presses.push_back('{1'b0, 3'd0, 3'd0, 1'b1, held});
        else
            foreach (item_presses[i])
                expected_presses.push_back(item_presses[i]);
        n_items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending until every expected beat has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_presses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_INITIAL_DELAY:   cfg_delay    = value[DELAY_W-1:0];
            CFG_REPEAT_INTERVAL: cfg_interval = value[DELAY_W-1:0];
            CFG_REPEAT_KEY_MASK: cfg_mask     = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // New timing and mask; bits above the 31-bit register fields carry noise
    task automatic set_timing(input logic [31:0] delay, input logic [31:0] interval,
                              input logic [63:0] mask);
        logic [63:0] word;
        drain();
        word = {$urandom, $urandom};
        word[DELAY_W-1:0] = delay[DELAY_W-1:0];
        write_reg(CFG_INITIAL_DELAY, word);
        word = {$urandom, $urandom};
        word[DELAY_W-1:0] = interval[DELAY_W-1:0];
        write_reg(CFG_REPEAT_INTERVAL, word);
        write_reg(CFG_REPEAT_KEY_MASK, mask);
        n_settings++;
    endtask

    // Next scan mostly evolves from the previous one so keys stay held
    function automatic logic [63:0] next_keys();
        int          r;
        logic [63:0] k;
        r = $urandom_range(0, 99);
        k = last_keys;
        if (r < 45)
            repeat ($urandom_range(0, 3)) k[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
        else if (r < 60)
            k = last_keys;
        else if (r < 70)
            k = '0;
        else if (r < 80)
            k = {$urandom, $urandom};
        else if (r < 85)
            k = '1;
        else
        begin
            k = '0;
            repeat ($urandom_range(1, 3)) k[$urandom_range(0, NUM_KEYS - 1)] = 1'b1;
        end
        return k;
    endfunction

    task automatic run_phase(input int count, input logic [31:0] tick_span, input int mod_pct);
        int       r;
        kpa_req_t req;
        logic     modif;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
                req = REQ_UI_SCAN;
            else if (r < 86)
                req = REQ_GAME_SCAN;
            else if (r < 93)
                req = REQ_CLR_UI;
            else
                req = REQ_CLR_GAME;
            last_keys = next_keys();
            modif = ($urandom_range(0, 99) < mod_pct);
            if ($urandom_range(0, 99) < 8)
                tick_cnt = $urandom;
            else
                tick_cnt = tick_cnt + $urandom_range(0, tick_span);
            send_item(req, last_keys, modif, tick_cnt, 1'b0, 1'b0);
        end
    endtask

    // Result side: random stalls, plus a long hold-off when asked
    initial
    begin : press_sink
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare every accepted beat with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_beats++;
            if (expected_presses.size() == 0)
            begin
                $error("unexpected beat: row %0d col %0d", m_tdata[2:0], m_tdata[5:3]);
                n_fail++;
            end
            else
            begin
                want = expected_presses.pop_front();
                if (want.press_valid)
                    n_presses++;
                if (m_tuser !== want.press_valid)
                begin
                    $error("press_valid: expected %0d, got %0d", want.press_valid, m_tuser);
                    n_fail++;
                end
                if (m_tdata[2:0] !== want.row)
                begin
                    $error("press_row: expected %0d, got %0d", want.row, m_tdata[2:0]);
                    n_fail++;
                end
                if (m_tdata[5:3] !== want.col)
                begin
                    $error("press_col: expected %0d, got %0d", want.col, m_tdata[5:3]);
                    n_fail++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_result: expected %0d, got %0d", want.last, m_tlast);
                    n_fail++;
                end
                if (m_tdata[6] !== want.held)
                begin
                    $error("any_ui_held: expected %0d, got %0d", want.held, m_tdata[6]);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        ui_held      = '0;
        game_held    = '0;
        armed        = '0;
        foreach (deadline[i])
            deadline[i] = '0;
        cfg_delay    = RST_INITIAL_DELAY;
        cfg_interval = RST_REPEAT_INTERVAL;
        cfg_mask     = RST_REPEAT_KEY_MASK;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset configuration
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_tab[i].req, dir_tab[i].keys, dir_tab[i].modif, dir_tab[i].tick,
                      dir_tab[i].quiet, dir_tab[i].held);

        // Short repeat timing, random mask; sender pauses mid-phase
        set_timing(32'd20, 32'd5, {$urandom, $urandom});
        run_phase(25, 32'd12, 10);
        drain();
        run_phase(25, 32'd12, 10);

        // Zero delays, every key repeatable, no idling at all
        set_timing(32'd0, 32'd0, '1);
        idle_on = 1'b0;
        run_phase(50, 32'd3, 10);
        idle_on = 1'b1;

        // Largest delays; ticks jump across the signed compare boundary
        set_timing(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
        run_phase(45, 32'hFFFF_FFFF, 10);

        // Random timing; receiver holds off while requests keep coming
        set_timing($urandom_range(0, 200), $urandom_range(0, 50), {$urandom, $urandom});
        sink_hold = 400;
        idle_on   = 1'b0;
        run_phase(10, 32'd60, 15);
        idle_on   = 1'b1;
        run_phase(40, 32'd60, 15);

        // Random wide timing, no repeatable keys
        set_timing($urandom, $urandom, '0);
        run_phase(60, 32'd1000, 10);

        s_tvalid <= 1'b0;
        while (expected_presses.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Covered %0d requests over %0d register settings", n_items, n_settings);
        $display("Checked %0d result beats, %0d of them key presses", n_beats, n_presses);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/core/kpa_pkg.sv
rtl/core/kpa_front.sv
rtl/core/kpa_back.sv
rtl/core/keypad_press_autorepeat.sv
bench/testbench.sv
